// ===== rtl/core/gsp_pkg.sv =====
// ---------------------------------------------------------------------------
// gsp_pkg
// Shared types and codes of the generational slot pool.
// ---------------------------------------------------------------------------
package gsp_pkg;

   localparam int SLOTS_DEF    = 64;
   localparam int GEN_BITS_DEF = 16;

   localparam logic [2:0] REQ_ALLOC   = 3'd0;
   localparam logic [2:0] REQ_ACCESS  = 3'd1;
   localparam logic [2:0] REQ_SET     = 3'd2;
   localparam logic [2:0] REQ_DESTROY = 3'd3;
   localparam logic [2:0] REQ_TICK    = 3'd4;
   localparam logic [2:0] REQ_COLLECT = 3'd5;
   localparam logic [2:0] REQ_PIN     = 3'd6;
   localparam logic [2:0] REQ_UNPIN   = 3'd7;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_STALE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_NONE  = 2'd3;

   localparam logic [2:0] KIND_NONE = 3'd0;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  kind;
      logic [5:0]  slot_index;
      logic [15:0] slot_generation;
      logic [63:0] device_handle;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  out_index;
      logic [15:0] out_generation;
      logic [2:0]  out_kind;
      logic [63:0] out_device_handle;
      logic        out_deferred;
      logic        last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_AGEN,
      ST_CHK,
      ST_SCAN
   } state_type;

endpackage

// ===== rtl/core/generational_slot_pool_core.sv =====
// ---------------------------------------------------------------------------
// generational_slot_pool_core
// Pool of slots named by index and generation, with free list, per-slot
// records, frame ageing and collection of stale unpinned slots.
// ---------------------------------------------------------------------------
// Tick, alloc of a fresh slot and the pool full answer are registered in the
// accept cycle and shown in the cycle after it; access, set handle and destroy
// read the slot record, then write it back (pin and unpin only read it); alloc
// from the free list reads the stack, then the record, then writes it. Collect
// walks the slot record memory one index per cycle, holds each freed slot until
// the next hit or the end of the walk, then sends it through the output register.
// The receiver cannot stall: every rsp_valid pulse is one item, taken as is.
// ---------------------------------------------------------------------------
module generational_slot_pool_core #(
   parameter int SLOTS    = gsp_pkg::SLOTS_DEF,
   parameter int GEN_BITS = gsp_pkg::GEN_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  gsp_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output gsp_pkg::rsp_item_type rsp_item,
   input  logic                  csr_we,
   input  logic [31:0]           csr_wdata
);
   import gsp_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ENT_W = GEN_BITS + 3 + 1 + 64 + 32;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(SLOTS);

   typedef struct packed {
      logic [GEN_BITS-1:0] gen;
      logic [2:0]          kind;
      logic                deferred;
      logic [63:0]         handle;
      logic [31:0]         last_used;
   } entry_type;

   state_type        state_ff, state_in;
   req_item_type     req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             chk_ok_ff, chk_ok_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] high_water_ff, high_water_in;
   logic [31:0]      frame_ff, frame_in;
   logic [31:0]      max_frames_ff;
   logic [SLOTS-1:0] alive_ff, alive_in;
   logic [SLOTS-1:0] pinned_ff, pinned_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             pend_vld_ff, pend_vld_in;
   rsp_item_type     pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   entry_type        mem_wdata, rd_ent;
   logic [ENT_W-1:0] rd_raw;
   logic             stk_push, stk_pop;
   logic [IDX_W-1:0] stk_paddr, stk_raddr, stk_pdata, stk_rdata;
   logic [IDX_W-1:0] req_idx;
   logic             req_in_range;

   gsp_slot_ram #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_raw)
   );

   gsp_free_stack #(.SLOTS(SLOTS)) u_free_stack (
      .clock     (clock),
      .push      (stk_push),
      .push_addr (stk_paddr),
      .push_data (stk_pdata),
      .pop       (stk_pop),
      .pop_addr  (stk_raddr),
      .pop_data  (stk_rdata)
   );

   assign rd_ent       = entry_type'(rd_raw);
   assign req_idx      = IDX_W'(req_item.slot_index);
   assign req_in_range = 32'(req_item.slot_index) < 32'(high_water_ff);

   function automatic rsp_item_type make_rsp(logic [IDX_W-1:0] idx, entry_type e,
                                             logic is_last);
      rsp_item_type r;
      r.status            = STAT_OK;
      r.out_index         = 6'(32'(idx));
      r.out_generation    = 16'(32'(e.gen));
      r.out_kind          = e.kind;
      r.out_device_handle = e.handle;
      r.out_deferred      = e.deferred;
      r.last              = is_last;
      return r;
   endfunction

   function automatic rsp_item_type blank_rsp(logic [1:0] st);
      rsp_item_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_count_ff <= '0;
         high_water_ff <= '0;
         frame_ff      <= '0;
         max_frames_ff <= 32'd2;
         alive_ff      <= '0;
         pinned_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         high_water_ff <= high_water_in;
         frame_ff      <= frame_in;
         alive_ff      <= alive_in;
         pinned_ff     <= pinned_in;
         cmp_vld_ff    <= cmp_vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            max_frames_ff <= csr_wdata;
         end
      end
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      chk_ok_ff  <= chk_ok_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      entry_type e;
      logic      hit;
      e             = rd_ent;
      hit           = 1'b0;
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      chk_ok_in     = chk_ok_ff;
      free_count_in = free_count_ff;
      high_water_in = high_water_ff;
      frame_in      = frame_ff;
      alive_in      = alive_ff;
      pinned_in     = pinned_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = rd_ent;
      mem_re        = 1'b0;
      mem_raddr     = req_idx;
      stk_push      = 1'b0;
      stk_paddr     = IDX_W'(free_count_ff);
      stk_pdata     = idx_ff;
      stk_pop       = 1'b0;
      stk_raddr     = IDX_W'(free_count_ff - 1'b1);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               case (req_item.req_type)
                  REQ_ALLOC: begin
                     if (free_count_ff != '0) begin
                        stk_pop       = 1'b1;
                        free_count_in = free_count_ff - 1'b1;
                        state_in      = ST_POP;
                     end else if (high_water_ff != FULL) begin
                        e.gen         = '0;
                        e.kind        = req_item.kind;
                        e.deferred    = 1'b1;
                        e.handle      = '0;
                        e.last_used   = frame_ff;
                        mem_we        = 1'b1;
                        mem_waddr     = IDX_W'(high_water_ff);
                        mem_wdata     = e;
                        alive_in[IDX_W'(high_water_ff)]  = 1'b1;
                        pinned_in[IDX_W'(high_water_ff)] = 1'b0;
                        high_water_in = high_water_ff + 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_in        = make_rsp(IDX_W'(high_water_ff), e, 1'b1);
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = blank_rsp(STAT_FULL);
                     end
                  end
                  REQ_TICK: begin
                     frame_in     = frame_ff + 32'd1;
                     rsp_valid_in = 1'b1;
                     rsp_in       = blank_rsp(STAT_OK);
                  end
                  REQ_COLLECT: begin
                     scan_in     = '0;
                     pend_vld_in = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     mem_re    = 1'b1;
                     idx_in    = req_idx;
                     chk_ok_in = req_in_range && alive_ff[req_idx];
                     state_in  = ST_CHK;
                  end
               endcase
            end
         end
         ST_POP: begin
            idx_in    = stk_rdata;
            mem_re    = 1'b1;
            mem_raddr = stk_rdata;
            state_in  = ST_AGEN;
         end
         ST_AGEN: begin
            e.gen       = rd_ent.gen + 1'b1;
            e.kind      = req_ff.kind;
            e.deferred  = 1'b1;
            e.handle    = '0;
            e.last_used = frame_ff;
            mem_we      = 1'b1;
            mem_wdata   = e;
            alive_in[idx_ff]  = 1'b1;
            pinned_in[idx_ff] = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(idx_ff, e, 1'b1);
            state_in     = ST_IDLE;
         end
         ST_CHK: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (!chk_ok_ff || 32'(rd_ent.gen) != 32'(req_ff.slot_generation)) begin
               rsp_in = blank_rsp(STAT_STALE);
            end else begin
               case (req_ff.req_type)
                  REQ_ACCESS: begin
                     e.last_used = frame_ff;
                     mem_we      = 1'b1;
                  end
                  REQ_SET: begin
                     e.handle   = req_ff.device_handle;
                     e.deferred = 1'b0;
                     mem_we     = 1'b1;
                  end
                  REQ_DESTROY: begin
                     e.kind            = KIND_NONE;
                     mem_we            = 1'b1;
                     alive_in[idx_ff]  = 1'b0;
                     pinned_in[idx_ff] = 1'b0;
                     if (free_count_ff != FULL) begin
                        stk_push      = 1'b1;
                        free_count_in = free_count_ff + 1'b1;
                     end
                  end
                  REQ_PIN: begin
                     pinned_in[idx_ff] = 1'b1;
                  end
                  default: begin
                     pinned_in[idx_ff] = 1'b0;
                  end
               endcase
               mem_wdata = e;
               rsp_in    = make_rsp(idx_ff, e, 1'b1);
            end
         end
         ST_SCAN: begin
            if (scan_ff < high_water_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = IDX_W'(scan_ff);
               cmp_vld_in = 1'b1;
               cmp_idx_in = IDX_W'(scan_ff);
               scan_in    = scan_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               hit = alive_ff[cmp_idx_ff] && !pinned_ff[cmp_idx_ff] &&
                     ((frame_ff - rd_ent.last_used) > max_frames_ff);
               if (hit) begin
                  e.kind                = KIND_NONE;
                  mem_we                = 1'b1;
                  mem_waddr             = cmp_idx_ff;
                  mem_wdata             = e;
                  alive_in[cmp_idx_ff]  = 1'b0;
                  pinned_in[cmp_idx_ff] = 1'b0;
                  if (free_count_ff != FULL) begin
                     stk_push      = 1'b1;
                     stk_pdata     = cmp_idx_ff;
                     free_count_in = free_count_ff + 1'b1;
                  end
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_vld_in = 1'b1;
                  pend_in     = make_rsp(cmp_idx_ff, rd_ent, 1'b0);
               end
            end else if (scan_ff >= high_water_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               pend_vld_in  = 1'b0;
               if (pend_vld_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = blank_rsp(STAT_NONE);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_free_le_hw: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= high_water_ff)
      else $error("free count exceeds high water");

   a_err_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != STAT_OK |-> rsp_item.out_device_handle == '0
         && rsp_item.out_index == '0 && rsp_item.last)
      else $error("error item carries slot data");

   a_mid_collect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> state_ff == ST_SCAN)
      else $error("non-final item outside collection");

   a_hw_bound: assert property (@(posedge clock) disable iff (reset)
      high_water_ff <= FULL)
      else $error("high water beyond pool size");
endmodule

// ===== rtl/core/gsp_slot_ram.sv =====
// ---------------------------------------------------------------------------
// gsp_slot_ram
// Per-slot record memory: generation, kind, deferred, backend handle and
// last-used frame. One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module gsp_slot_ram #(
   parameter int SLOTS    = gsp_pkg::SLOTS_DEF,
   parameter int GEN_BITS = gsp_pkg::GEN_BITS_DEF,
   localparam int IDX_W   = $clog2(SLOTS),
   localparam int ENT_W   = GEN_BITS + 3 + 1 + 64 + 32
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [ENT_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [ENT_W-1:0] rd_data
);
   logic [ENT_W-1:0] mem [SLOTS];
   logic [ENT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/gsp_free_stack.sv =====
// ---------------------------------------------------------------------------
// gsp_free_stack
// Storage of freed slot indexes, newest on top. The pool keeps the count.
// ---------------------------------------------------------------------------
module gsp_free_stack #(
   parameter int SLOTS  = gsp_pkg::SLOTS_DEF,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic             clock,
   input  logic             push,
   input  logic [IDX_W-1:0] push_addr,
   input  logic [IDX_W-1:0] push_data,
   input  logic             pop,
   input  logic [IDX_W-1:0] pop_addr,
   output logic [IDX_W-1:0] pop_data
);
   logic [IDX_W-1:0] mem [SLOTS];
   logic [IDX_W-1:0] pop_data_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[push_addr] <= push_data;
      end
      if (pop) begin
         pop_data_ff <= mem[pop_addr];
      end
   end

   assign pop_data = pop_data_ff;
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives random and directed pool requests into the slot pool core, keeps
// its own model of slots, generations, free list and frame ages, and checks
// every result item in order against the model's prediction.
// ---------------------------------------------------------------------------
class pool_scoreboard;
   bit          alive [64];
   bit [15:0]   gen_tab [64];
   bit [2:0]    kind_tab [64];
   bit          defer_tab [64];
   bit [63:0]   dev_tab [64];
   bit [31:0]   used_tab [64];
   bit          pin_tab [64];
   bit [5:0]    free_stk [64];
   int          free_cnt;
   int          high_water;
   bit [31:0]   frame;
   bit [31:0]   max_age;
   gsp_pkg::rsp_item_type pending [$];
   int          errors;
   int          checked;

   function new();
      for (int i = 0; i < 64; i++) begin
         alive[i] = 1'b0; gen_tab[i] = '0; kind_tab[i] = '0; defer_tab[i] = 1'b1;
         dev_tab[i] = '0; used_tab[i] = '0; pin_tab[i] = 1'b0; free_stk[i] = '0;
      end
      free_cnt = 0; high_water = 0; frame = '0; max_age = 32'd2;
      errors = 0; checked = 0;
   endfunction

   function void add_expected(gsp_pkg::rsp_item_type r);
      pending.insert(pending.size(), r);
   endfunction

   function gsp_pkg::rsp_item_type slot_result(int i, bit lst);
      gsp_pkg::rsp_item_type r;
      r = '0;
      r.status = gsp_pkg::STAT_OK;
      r.out_index = 6'(i);
      r.out_generation = gen_tab[i];
      r.out_kind = kind_tab[i];
      r.out_device_handle = dev_tab[i];
      r.out_deferred = defer_tab[i];
      r.last = lst;
      return r;
   endfunction

   function gsp_pkg::rsp_item_type code_result(logic [1:0] st);
      gsp_pkg::rsp_item_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function void release_slot(int i);
      alive[i] = 1'b0; kind_tab[i] = gsp_pkg::KIND_NONE; pin_tab[i] = 1'b0;
      if (free_cnt < 64) begin
         free_stk[free_cnt] = 6'(i);
         free_cnt++;
      end
   endfunction

   function void note_item(gsp_pkg::req_item_type q);
      int i;
      int n;
      n = 0;
      i = int'(q.slot_index);
      case (q.req_type)
         gsp_pkg::REQ_ALLOC: begin
            if (free_cnt > 0) begin
               free_cnt--;
               i = int'(free_stk[free_cnt]);
               gen_tab[i] = gen_tab[i] + 16'd1;
            end else if (high_water < 64) begin
               i = high_water;
               high_water++;
               gen_tab[i] = '0;
            end else begin
               add_expected(code_result(gsp_pkg::STAT_FULL));
               return;
            end
            alive[i] = 1'b1; kind_tab[i] = q.kind; defer_tab[i] = 1'b1; dev_tab[i] = '0;
            pin_tab[i] = 1'b0; used_tab[i] = frame;
            add_expected(slot_result(i, 1'b1));
         end
         gsp_pkg::REQ_TICK: begin
            frame++;
            add_expected(code_result(gsp_pkg::STAT_OK));
         end
         gsp_pkg::REQ_COLLECT: begin
            for (int k = 0; k < high_water; k++) begin
               if (alive[k] && !pin_tab[k] && (frame - used_tab[k]) > max_age) begin
                  add_expected(slot_result(k, 1'b0));
                  n++;
                  release_slot(k);
               end
            end
            if (n == 0) add_expected(code_result(gsp_pkg::STAT_NONE));
            else pending[pending.size() - 1].last = 1'b1;
         end
         default: begin
            if (i >= high_water || !alive[i] || gen_tab[i] != q.slot_generation) begin
               add_expected(code_result(gsp_pkg::STAT_STALE));
               return;
            end
            case (q.req_type)
               gsp_pkg::REQ_ACCESS:  used_tab[i] = frame;
               gsp_pkg::REQ_SET: begin
                  dev_tab[i] = q.device_handle;
                  defer_tab[i] = 1'b0;
               end
               gsp_pkg::REQ_DESTROY: release_slot(i);
               gsp_pkg::REQ_PIN:     pin_tab[i] = 1'b1;
               default:              pin_tab[i] = 1'b0;
            endcase
            add_expected(slot_result(i, 1'b1));
         end
      endcase
   endfunction

   function void check_result(gsp_pkg::rsp_item_type a);
      gsp_pkg::rsp_item_type e;
      checked++;
      if (pending.size() == 0) begin
         $error("unexpected result item %p", a);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
         $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.out_index !== e.out_index) begin
         $error("out_index exp %0d got %0d", e.out_index, a.out_index); errors++;
      end
      if (a.out_generation !== e.out_generation) begin
         $error("out_generation exp %0d got %0d", e.out_generation, a.out_generation);
         errors++;
      end
      if (a.out_kind !== e.out_kind) begin
         $error("out_kind exp %0d got %0d", e.out_kind, a.out_kind); errors++;
      end
      if (a.out_device_handle !== e.out_device_handle) begin
         $error("out_device_handle exp %h got %h", e.out_device_handle,
                a.out_device_handle);
         errors++;
      end
      if (a.out_deferred !== e.out_deferred) begin
         $error("out_deferred exp %0d got %0d", e.out_deferred, a.out_deferred); errors++;
      end
      if (a.last !== e.last) begin
         $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
   endfunction
endclass

module testbench;
   import gsp_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         start = 0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_we = 0;
   logic [31:0]  csr_wdata = '0;

   pool_scoreboard pool;
   bit             calm;
   int             sent;
   int             kinds_seen [8];

   generational_slot_pool_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) pool.check_result(rsp_item);
   end

   task automatic send_item(req_item_type q);
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      pool.note_item(q);
      kinds_seen[q.req_type]++;
      sent++;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pool.pending.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic write_age(logic [31:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      pool.max_age = v;
   endtask

   function automatic req_item_type make_req(logic [2:0] t, int i);
      req_item_type q;
      q.req_type = t;
      q.kind = 3'($urandom_range(0, 7));
      q.slot_index = 6'(i);
      q.slot_generation = (i < pool.high_water) ? pool.gen_tab[i] : 16'($urandom);
      q.device_handle = {$urandom, $urandom};
      return q;
   endfunction

   task automatic random_phase(int count);
      req_item_type q;
      int r;
      int i;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         i = (pool.high_water > 0) ? $urandom_range(0, pool.high_water - 1) : 0;
         if (r < 25) q = make_req(REQ_ALLOC, i);
         else if (r < 40) q = make_req(REQ_ACCESS, i);
         else if (r < 52) q = make_req(REQ_SET, i);
         else if (r < 60) q = make_req(REQ_DESTROY, i);
         else if (r < 75) q = make_req(REQ_TICK, i);
         else if (r < 82) q = make_req(REQ_COLLECT, i);
         else if (r < 88) q = make_req(REQ_PIN, i);
         else if (r < 93) q = make_req(REQ_UNPIN, i);
         else begin
            q = make_req(3'($urandom_range(0, 7)), $urandom_range(0, 63));
            if (q.req_type != REQ_ALLOC && q.req_type != REQ_TICK
                && q.req_type != REQ_COLLECT && $urandom_range(0, 1))
               q.slot_generation = q.slot_generation ^ 16'(1 << $urandom_range(0, 15));
         end
         send_item(q);
      end
   endtask

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      req_item_type q;
      pool = new();
      sent = 0;
      calm = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stale checks, extremes, every request type
      send_item(make_req(REQ_ACCESS, 0));
      send_item(make_req(REQ_COLLECT, 0));
      q = make_req(REQ_ALLOC, 0); q.kind = 3'd7; send_item(q);
      q = make_req(REQ_ALLOC, 0); q.kind = 3'd0; send_item(q);
      q = make_req(REQ_SET, 0); q.device_handle = '1; send_item(q);
      q = make_req(REQ_SET, 1); q.device_handle = '0; send_item(q);
      q = make_req(REQ_ACCESS, 0); q.slot_generation = 16'hFFFF; send_item(q);
      send_item(make_req(REQ_ACCESS, 0));
      send_item(make_req(REQ_PIN, 0));
      repeat (3) send_item(make_req(REQ_TICK, 0));
      send_item(make_req(REQ_COLLECT, 0));
      send_item(make_req(REQ_UNPIN, 0));
      send_item(make_req(REQ_DESTROY, 0));
      send_item(make_req(REQ_DESTROY, 0));
      send_item(make_req(REQ_ALLOC, 63));
      q = make_req(REQ_PIN, 63); q.slot_index = 6'd63; send_item(q);

      write_age(32'd0);
      random_phase(60);
      // fill the pool to reach full
      for (int n = 0; n < 66; n++) send_item(make_req(REQ_ALLOC, 0));
      drain();
      write_age(32'hFFFF_FFFF);
      random_phase(50);
      write_age(32'd1);
      random_phase(70);
      write_age(32'd3);
      random_phase(60);
      calm = 1;
      random_phase(40);
      send_item(make_req(REQ_COLLECT, 0));
      drain();

      $display("Sent %0d items: alloc %0d access %0d set %0d destroy %0d", sent,
               kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
      $display("tick %0d collect %0d pin %0d unpin %0d, %0d results checked",
               kinds_seen[4], kinds_seen[5], kinds_seen[6], kinds_seen[7], pool.checked);
      if (pool.errors == 0 && pool.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
